>>> sv/tgc_pkg.sv
// Shared types, codes and arithmetic helpers of the touchpad gesture classifier.
`default_nettype none
package tgc_pkg;

    localparam int ACC_WIDTH   = 24;
    localparam int DELTA_WIDTH = 16;
    localparam int SCALE_WIDTH = 16;
    localparam int THR_WIDTH   = 16;
    localparam int RATIO_WIDTH = 10;
    localparam int PROD_WIDTH  = SCALE_WIDTH + RATIO_WIDTH;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [THR_WIDTH-1:0]   THR_RESET   = THR_WIDTH'(320);
    localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = RATIO_WIDTH'(384);
    localparam logic [SCALE_WIDTH-1:0] SCALE_UNITY = SCALE_WIDTH'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PINCH_RATIO     = CFG_IDX_W'(1);

    localparam logic [2:0] REQ_SWIPE_BEGIN  = 3'd0;
    localparam logic [2:0] REQ_SWIPE_UPDATE = 3'd1;
    localparam logic [2:0] REQ_SWIPE_END    = 3'd2;
    localparam logic [2:0] REQ_PINCH_BEGIN  = 3'd3;
    localparam logic [2:0] REQ_PINCH_UPDATE = 3'd4;
    localparam logic [2:0] REQ_PINCH_END    = 3'd5;

    localparam logic [2:0] CMD_NONE         = 3'd0;
    localparam logic [2:0] CMD_BEGIN        = 3'd1;
    localparam logic [2:0] CMD_SWIPE_UPDATE = 3'd2;
    localparam logic [2:0] CMD_SWIPE_END    = 3'd3;
    localparam logic [2:0] CMD_PINCH_UPDATE = 3'd4;
    localparam logic [2:0] CMD_PINCH_END    = 3'd5;

    localparam logic KIND_SWIPE = 1'b0;
    localparam logic KIND_PINCH = 1'b1;

    localparam logic [1:0] PHASE_UPDATE    = 2'd0;
    localparam logic [1:0] PHASE_FINISHED  = 2'd1;
    localparam logic [1:0] PHASE_CANCELLED = 2'd2;

    localparam logic [2:0] DIR_NONE     = 3'd0;
    localparam logic [2:0] DIR_LEFT     = 3'd1;
    localparam logic [2:0] DIR_RIGHT    = 3'd2;
    localparam logic [2:0] DIR_UP       = 3'd3;
    localparam logic [2:0] DIR_DOWN     = 3'd4;
    localparam logic [2:0] DIR_ZOOM_IN  = 3'd5;
    localparam logic [2:0] DIR_ZOOM_OUT = 3'd6;

    typedef logic signed [ACC_WIDTH-1:0] acc_t;
    typedef logic        [ACC_WIDTH-1:0] mag_t;

    typedef struct packed {
        logic [2:0]                    req_type;
        logic [2:0]                    finger_count;
        logic                          cancelled;
        logic signed [DELTA_WIDTH-1:0] delta_x;
        logic signed [DELTA_WIDTH-1:0] delta_y;
        logic [SCALE_WIDTH-1:0]        scale;
    } in_item_t;

    typedef struct packed {
        logic       gesture_kind;
        logic [2:0] fingers;
        logic [1:0] phase;
        logic [2:0] direction;
    } out_item_t;

    typedef struct packed {
        logic [2:0]                    cmd;
        logic [2:0]                    fingers;
        logic                          cancelled;
        logic signed [DELTA_WIDTH-1:0] delta_x;
        logic signed [DELTA_WIDTH-1:0] delta_y;
        logic [SCALE_WIDTH-1:0]        scale;
    } cmd_item_t;

    function automatic acc_t sat_add(acc_t a, logic signed [DELTA_WIDTH-1:0] d);
        logic signed [ACC_WIDTH:0] s;
        acc_t                      r;
        s = {a[ACC_WIDTH-1], a} + {{(ACC_WIDTH + 1 - DELTA_WIDTH){d[DELTA_WIDTH-1]}}, d};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            r = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            r = s[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic mag_t magnitude(acc_t a);
        return a[ACC_WIDTH-1] ? mag_t'(~a + 1'b1) : mag_t'(a);
    endfunction

endpackage
`default_nettype wire

>>> sv/tgc_front.sv
// Front end: accepts input beats and turns each request type into a queue command.
`default_nettype none
module tgc_front (
    input  wire tgc_pkg::in_item_t  s_data,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire                     q_ready,
    output logic                    q_push,
    output tgc_pkg::cmd_item_t      q_entry
);
    import tgc_pkg::*;

    logic [2:0] cmd;

    always_comb begin
        unique case (s_data.req_type) inside
            REQ_SWIPE_BEGIN, REQ_PINCH_BEGIN: cmd = CMD_BEGIN;
            REQ_SWIPE_UPDATE:                 cmd = CMD_SWIPE_UPDATE;
            REQ_SWIPE_END:                    cmd = CMD_SWIPE_END;
            REQ_PINCH_UPDATE:                 cmd = CMD_PINCH_UPDATE;
            REQ_PINCH_END:                    cmd = CMD_PINCH_END;
            default:                          cmd = CMD_NONE;
        endcase
    end

    // Unused request types are taken and dropped here.
    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready && (cmd != CMD_NONE);

    always_comb begin
        q_entry.cmd       = cmd;
        q_entry.fingers   = s_data.finger_count;
        q_entry.cancelled = s_data.cancelled;
        q_entry.delta_x   = s_data.delta_x;
        q_entry.delta_y   = s_data.delta_y;
        q_entry.scale     = s_data.scale;
    end

endmodule
`default_nettype wire

>>> sv/tgc_queue.sv
// Short command queue that decouples the front end from the gesture engine.
`default_nettype none
module tgc_queue (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       push,
    input  wire tgc_pkg::cmd_item_t   push_entry,
    output logic                      push_ready,
    input  wire                       pop,
    output logic                      pop_valid,
    output tgc_pkg::cmd_item_t        pop_entry
);
    import tgc_pkg::*;

    cmd_item_t         entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

>>> sv/tgc_back.sv
// Gesture engine: accumulators, pinch reference, configuration and the result register.
`default_nettype none
module tgc_back (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_write,
    input  wire [tgc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [tgc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                 q_valid,
    input  wire tgc_pkg::cmd_item_t             q_entry,
    output logic                                q_pop,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output tgc_pkg::out_item_t                  m_data
);
    import tgc_pkg::*;

    logic [THR_WIDTH-1:0]   thr_reg;
    logic [RATIO_WIDTH-1:0] ratio_reg;

    acc_t                   total_x_reg, total_x_next;
    acc_t                   total_y_reg, total_y_next;
    acc_t                   step_x_reg, step_x_next;
    acc_t                   step_y_reg, step_y_next;
    logic [2:0]             fingers_reg, fingers_next;
    logic [SCALE_WIDTH-1:0] cur_scale_reg, cur_scale_next;
    logic [SCALE_WIDTH-1:0] ref_scale_reg, ref_scale_next;
    logic                   ref_valid_reg, ref_valid_next;

    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    acc_t                   sum_tx, sum_ty, sum_sx, sum_sy;
    mag_t                   mag_sx, mag_sy, mag_tx, mag_ty, thr_ext;
    logic signed [ACC_WIDTH:0] thr_pos, thr_neg, tx_ext, ty_ext;
    logic [PROD_WIDTH-1:0]  sc_shift, ref_shift, ratio_ref, ratio_sc;
    logic                   step_fire, pinch_fire, has_result;
    logic [2:0]             step_dir, end_dir;
    out_item_t              result;

    assign q_pop   = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sum_tx  = sat_add(total_x_reg, q_entry.delta_x);
        sum_ty  = sat_add(total_y_reg, q_entry.delta_y);
        sum_sx  = sat_add(step_x_reg, q_entry.delta_x);
        sum_sy  = sat_add(step_y_reg, q_entry.delta_y);
        mag_sx  = magnitude(sum_sx);
        mag_sy  = magnitude(sum_sy);
        mag_tx  = magnitude(total_x_reg);
        mag_ty  = magnitude(total_y_reg);
        thr_ext = {{(ACC_WIDTH - THR_WIDTH){1'b0}}, thr_reg};
        thr_pos = {1'b0, thr_ext};
        thr_neg = -thr_pos;
        tx_ext  = {total_x_reg[ACC_WIDTH-1], total_x_reg};
        ty_ext  = {total_y_reg[ACC_WIDTH-1], total_y_reg};

        step_fire = (mag_sx > thr_ext) || (mag_sy > thr_ext);
        if (mag_sx > mag_sy) begin
            step_dir = (!sum_sx[ACC_WIDTH-1] && (sum_sx != '0)) ? DIR_RIGHT : DIR_LEFT;
        end else begin
            step_dir = (!sum_sy[ACC_WIDTH-1] && (sum_sy != '0)) ? DIR_DOWN : DIR_UP;
        end

        if (mag_tx > mag_ty) begin
            end_dir = (tx_ext > thr_pos) ? DIR_RIGHT : ((tx_ext < thr_neg) ? DIR_LEFT : DIR_NONE);
        end else begin
            end_dir = (ty_ext > thr_pos) ? DIR_DOWN : ((ty_ext < thr_neg) ? DIR_UP : DIR_NONE);
        end

        sc_shift   = {{(RATIO_WIDTH - 8){1'b0}}, q_entry.scale, 8'd0};
        ref_shift  = {{(RATIO_WIDTH - 8){1'b0}}, ref_scale_reg, 8'd0};
        ratio_ref  = PROD_WIDTH'(ratio_reg) * PROD_WIDTH'(ref_scale_reg);
        ratio_sc   = PROD_WIDTH'(ratio_reg) * PROD_WIDTH'(q_entry.scale);
        pinch_fire = (sc_shift > ratio_ref) || (ref_shift > ratio_sc);
    end

    always_comb begin
        total_x_next   = total_x_reg;
        total_y_next   = total_y_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        fingers_next   = fingers_reg;
        cur_scale_next = cur_scale_reg;
        ref_scale_next = ref_scale_reg;
        ref_valid_next = ref_valid_reg;
        has_result     = 1'b0;
        result         = '{gesture_kind: KIND_SWIPE, fingers: fingers_reg,
                           phase: PHASE_UPDATE, direction: DIR_NONE};

        case (q_entry.cmd) inside
            CMD_BEGIN: begin
                total_x_next   = '0;
                total_y_next   = '0;
                step_x_next    = '0;
                step_y_next    = '0;
                fingers_next   = q_entry.fingers;
                cur_scale_next = '0;
                ref_scale_next = '0;
                ref_valid_next = 1'b0;
            end
            CMD_SWIPE_UPDATE: begin
                total_x_next = sum_tx;
                total_y_next = sum_ty;
                step_x_next  = sum_sx;
                step_y_next  = sum_sy;
                if (step_fire) begin
                    has_result       = 1'b1;
                    result.direction = step_dir;
                    step_x_next      = '0;
                    step_y_next      = '0;
                end
            end
            CMD_SWIPE_END, CMD_PINCH_END: begin
                has_result     = 1'b1;
                result.fingers = q_entry.fingers;
                if (q_entry.cmd == CMD_SWIPE_END) begin
                    result.gesture_kind = KIND_SWIPE;
                    if (q_entry.cancelled) begin
                        result.phase = PHASE_CANCELLED;
                    end else begin
                        result.phase     = PHASE_FINISHED;
                        result.direction = end_dir;
                    end
                end else begin
                    result.gesture_kind = KIND_PINCH;
                    if (!q_entry.cancelled || (cur_scale_reg != '0)) begin
                        result.phase     = PHASE_FINISHED;
                        result.direction = (cur_scale_reg > SCALE_UNITY) ? DIR_ZOOM_IN
                                                                          : DIR_ZOOM_OUT;
                    end else begin
                        result.phase = PHASE_CANCELLED;
                    end
                end
                total_x_next   = '0;
                total_y_next   = '0;
                step_x_next    = '0;
                step_y_next    = '0;
                fingers_next   = '0;
                cur_scale_next = '0;
                ref_scale_next = '0;
                ref_valid_next = 1'b0;
            end
            CMD_PINCH_UPDATE: begin
                cur_scale_next = q_entry.scale;
                if (!ref_valid_reg) begin
                    ref_scale_next = q_entry.scale;
                    ref_valid_next = 1'b1;
                end else if (pinch_fire) begin
                    has_result          = 1'b1;
                    result.gesture_kind = KIND_PINCH;
                    result.direction    = (q_entry.scale > ref_scale_reg) ? DIR_ZOOM_IN
                                                                          : DIR_ZOOM_OUT;
                    ref_scale_next      = q_entry.scale;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (q_pop && has_result) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= THR_RESET;
            ratio_reg     <= RATIO_RESET;
            total_x_reg   <= '0;
            total_y_reg   <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            fingers_reg   <= '0;
            cur_scale_reg <= '0;
            ref_scale_reg <= '0;
            ref_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_write && (cfg_index == CFG_SWIPE_THRESHOLD)) begin
                thr_reg <= cfg_data[THR_WIDTH-1:0];
            end
            if (cfg_write && (cfg_index == CFG_PINCH_RATIO)) begin
                ratio_reg <= cfg_data[RATIO_WIDTH-1:0];
            end
            if (q_pop) begin
                total_x_reg   <= total_x_next;
                total_y_reg   <= total_y_next;
                step_x_reg    <= step_x_next;
                step_y_reg    <= step_y_next;
                fingers_reg   <= fingers_next;
                cur_scale_reg <= cur_scale_next;
                ref_scale_reg <= ref_scale_next;
                ref_valid_reg <= ref_valid_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

>>> sv/touchpad_gesture_classifier.sv
// Top level of the touchpad gesture classifier.
// The block takes one gesture event beat per cycle on s_ while its command queue has room
// and gives at most one classified result beat per event on m_, in event order.
// An event is decoded and written into a two-entry command queue at the edge where it
// is accepted; the gesture engine takes one command per cycle from that queue while its
// result register is free or being read by m_ready, updates the swipe accumulators or
// the pinch reference, and loads its result register at the next edge.
// Throughput is one event per cycle, limited only by the single-command-per-cycle gesture
// engine and by m_ready. Configuration writes (index 0 swipe threshold, index 1 pinch
// ratio) are always accepted and should be issued only while no event is in flight.
`default_nettype none
module touchpad_gesture_classifier (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire tgc_pkg::in_item_t          s_data,
    output logic                            m_valid,
    input  wire                             m_ready,
    output tgc_pkg::out_item_t              m_data,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [tgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [tgc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tgc_pkg::*;

    logic      q_ready, q_push, q_valid, q_pop;
    cmd_item_t push_entry, pop_entry;

    assign cfg_ready = 1'b1;

    tgc_front u_front (
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    tgc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    tgc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
